FILE: hw/rtl/wlc_pkg.sv
package wlc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int WT_W        = 32;
  localparam int SUM_W       = 36;
  localparam int OCC_OUT_W   = 5;
  localparam int DATA_W      = KEY_W + VAL_W + WT_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 3;
  localparam logic [SUM_W-1:0] WT_LIMIT_RST = 36'd1048576;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WT_LIMIT = '0;

  typedef enum logic [1:0] {
    OP_GET       = 2'd0,
    OP_PUT       = 2'd1,
    OP_INVAL     = 2'd2,
    OP_INVAL_ALL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    AGE_NOP,
    AGE_PROMOTE,
    AGE_REMOVE,
    AGE_INSERT
  } age_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DISPATCH,
    S_PROMO,
    S_UPD_SUB,
    S_UPD_ADD,
    S_INS_WR,
    S_LSCAN,
    S_LREAD,
    S_LDATA,
    S_RMV,
    S_EVCHK,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/weighted_lru_cache_top.sv
// Weight-bounded LRU cache of ENTRIES slots (key, value handle, weight).
// Pulse start while busy is low to issue one command word: get, put,
// invalidate one key or invalidate all. Busy stays high until the command
// finishes. Results come out on out_valid, one cycle each, and cannot be
// stalled: zero or more eviction notices (out_kind 0) then exactly one
// completion word (out_kind 1, out_last 1). Busy covers the key lookup
// (S_SCAN, one RAM read per cycle through the shared key comparator),
// S_SCAN_END to flush the last compare, S_DISPATCH, then S_PROMO to
// promote, S_INS_WR to insert or S_UPD_SUB and S_UPD_ADD to update, one
// weight check (S_EVCHK) after any change, per removal an LRU pick that
// walks the rank registers one slot per cycle (S_LSCAN), then read,
// remove and recheck, and S_DONE to complete. The completion word shows
// up in the same cycle that busy falls. The single 36-bit add/subtract
// unit updates the running weight. Key, value and weight live in one RAM;
// valid bits and recency ranks are flops. The weight limit register sits
// at APB address 0 (64-bit data); write it only when idle.
module weighted_lru_cache_top
  import wlc_pkg::*;
  #(parameter int ENTRIES = ENTRIES_DEF)
  (input  logic                   clk,
   input  logic                   rst_n,
   // command
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             in_op,
   input  logic [KEY_W-1:0]       in_key,
   input  logic [VAL_W-1:0]       in_value,
   input  logic [WT_W-1:0]        in_weight,
   // results
   output logic                   out_valid,
   output logic                   out_kind,
   output logic [KEY_W-1:0]       out_key_out,
   output logic [VAL_W-1:0]       out_value_out,
   output logic                   out_hit,
   output logic [OCC_OUT_W-1:0]   out_occupancy,
   output logic [SUM_W-1:0]       out_total_weight,
   output logic                   out_last,
   // configuration
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CFG_ADDR_W-1:0]  paddr,
   input  logic [CFG_DATA_W-1:0]  pwdata,
   output logic [CFG_DATA_W-1:0]  prdata,
   output logic                   pready);

  localparam int SW = $clog2(ENTRIES);
  localparam int OW = $clog2(ENTRIES+1);
  localparam logic [SW-1:0] LAST_IDX = SW'(ENTRIES-1);

  state_t state_r, state_nxt;

  // register file
  logic [SUM_W-1:0] max_r;
  assign pready = 1'b1;
  assign prdata = {{(CFG_DATA_W-SUM_W){1'b0}}, max_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= WT_LIMIT_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_WT_LIMIT) begin
      max_r <= pwdata[SUM_W-1:0];
    end
  end

  // command latches
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [WT_W-1:0]  w_r;

  // sequencer state
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    pend_idx_r, pend_idx_nxt;
  logic             pend_r, pend_nxt;
  logic             hit_r, hit_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [SW-1:0]    free_r, free_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic             ins_pend_r, ins_pend_nxt;
  logic [KEY_W-1:0] hold_key_r, hold_key_nxt;
  logic [VAL_W-1:0] hold_val_r, hold_val_nxt;
  logic [WT_W-1:0]  hold_w_r, hold_w_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // result word
  logic                 ov_r, ov_nxt;
  logic                 okind_r, okind_nxt;
  logic [KEY_W-1:0]     okey_r, okey_nxt;
  logic [VAL_W-1:0]     oval_r, oval_nxt;
  logic                 ohit_r, ohit_nxt;
  logic [OW-1:0]        oocc_r, oocc_nxt;
  logic [SUM_W-1:0]     osum_r, osum_nxt;
  logic                 olast_r, olast_nxt;
  logic [OW+OCC_OUT_W-1:0] occ_ext;

  // storage
  logic              ram_we;
  logic [SW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic [WT_W-1:0]   rd_w;
  age_op_t           age_op;
  logic [SW-1:0]     q_age;
  logic [ENTRIES-1:0] valid;
  logic [OW-1:0]     occ;

  assign {rd_key, rd_val, rd_w} = ram_rdata;
  assign ram_raddr = (state_r == S_SCAN) ? idx_r : slot_r;

  wlc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({key_r, val_r, w_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata));

  wlc_age #(.ENTRIES(ENTRIES)) u_age (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (age_op),
    .slot  (slot_r),
    .q_idx (idx_r),
    .q_age (q_age),
    .valid (valid),
    .occ   (occ));

  // shared weight adder
  logic             alu_sub;
  logic [WT_W-1:0]  alu_b;
  logic [SUM_W-1:0] alu_res;
  assign alu_sub = (state_r == S_RMV) || (state_r == S_UPD_SUB);
  assign alu_b   = alu_sub ? hold_w_r : w_r;
  assign alu_res = alu_sub ? sum_r - {{(SUM_W-WT_W){1'b0}}, alu_b}
                           : sum_r + {{(SUM_W-WT_W){1'b0}}, alu_b};

  // lookup compare on the word read last cycle
  logic match;
  logic fits;
  logic lru_hit;
  logic over;
  assign match   = pend_r && valid[pend_idx_r] && (rd_key == key_r) && !hit_r;
  assign fits    = {{(SUM_W-WT_W){1'b0}}, w_r} <= max_r;
  assign lru_hit = valid[idx_r] && (q_age == SW'(occ - 1'b1));
  assign over    = (sum_r > max_r) && (occ != '0);

  assign busy = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_SCAN;
      S_SCAN:     if (idx_r == LAST_IDX) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (op_r)
          OP_GET: begin
            if (hit_r)              state_nxt = S_PROMO;
            else if (!fits)         state_nxt = S_DONE;
            else if (free_vld_r)    state_nxt = S_INS_WR;
            else                    state_nxt = S_LSCAN;
          end
          OP_PUT: begin
            if (!fits)              state_nxt = S_DONE;
            else if (hit_r)         state_nxt = S_UPD_SUB;
            else if (free_vld_r)    state_nxt = S_INS_WR;
            else                    state_nxt = S_LSCAN;
          end
          OP_INVAL:     state_nxt = hit_r ? S_RMV : S_DONE;
          OP_INVAL_ALL: state_nxt = S_EVCHK;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_PROMO:    state_nxt = S_DONE;
      S_UPD_SUB:  state_nxt = S_UPD_ADD;
      S_UPD_ADD:  state_nxt = S_EVCHK;
      S_INS_WR:   state_nxt = S_EVCHK;
      S_LSCAN:    if (lru_hit) state_nxt = S_LREAD;
      S_LREAD:    state_nxt = S_LDATA;
      S_LDATA:    state_nxt = S_RMV;
      S_RMV: begin
        if (op_r == OP_INVAL) state_nxt = S_DONE;
        else if (ins_pend_r)  state_nxt = S_INS_WR;
        else                  state_nxt = S_EVCHK;
      end
      S_EVCHK: begin
        if (op_r == OP_INVAL_ALL) state_nxt = (occ != '0) ? S_LSCAN : S_DONE;
        else                      state_nxt = over ? S_LSCAN : S_DONE;
      end
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt      = '0;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    free_nxt     = free_r;
    free_vld_nxt = free_vld_r;
    ins_pend_nxt = ins_pend_r;
    hold_key_nxt = hold_key_r;
    hold_val_nxt = hold_val_r;
    hold_w_nxt   = hold_w_r;
    sum_nxt      = sum_r;
    ram_we       = 1'b0;
    age_op       = AGE_NOP;
    ov_nxt       = 1'b0;
    okind_nxt    = okind_r;
    okey_nxt     = okey_r;
    oval_nxt     = oval_r;
    ohit_nxt     = ohit_r;
    oocc_nxt     = oocc_r;
    osum_nxt     = osum_r;
    olast_nxt    = olast_r;

    unique case (state_r)
      S_IDLE: begin
        hit_nxt      = 1'b0;
        free_vld_nxt = 1'b0;
        ins_pend_nxt = 1'b0;
      end
      S_SCAN, S_SCAN_END: begin
        if (match) begin
          hit_nxt      = 1'b1;
          slot_nxt     = pend_idx_r;
          hold_key_nxt = rd_key;
          hold_val_nxt = rd_val;
          hold_w_nxt   = rd_w;
        end
        if (state_r == S_SCAN) begin
          if (!valid[idx_r] && !free_vld_r) begin
            free_nxt     = idx_r;
            free_vld_nxt = 1'b1;
          end
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
          idx_nxt      = idx_r + 1'b1;
        end
      end
      S_DISPATCH: begin
        // claim a slot only when this command inserts
        if (!hit_r && fits && (op_r == OP_GET || op_r == OP_PUT)) begin
          if (free_vld_r) slot_nxt = free_r;
          else            ins_pend_nxt = 1'b1;
        end
      end
      S_PROMO:   age_op = AGE_PROMOTE;
      S_UPD_SUB: sum_nxt = alu_res;
      S_UPD_ADD: begin
        sum_nxt = alu_res;
        ram_we  = 1'b1;
        age_op  = AGE_PROMOTE;
      end
      S_INS_WR: begin
        sum_nxt      = alu_res;
        ram_we       = 1'b1;
        age_op       = AGE_INSERT;
        ins_pend_nxt = 1'b0;
      end
      S_LSCAN: begin
        if (lru_hit) slot_nxt = idx_r;
        else         idx_nxt  = idx_r + 1'b1;
      end
      S_LREAD: ;
      S_LDATA: begin
        hold_key_nxt = rd_key;
        hold_val_nxt = rd_val;
        hold_w_nxt   = rd_w;
      end
      S_RMV: begin
        sum_nxt   = alu_res;
        age_op    = AGE_REMOVE;
        // null handles leave silently
        ov_nxt    = (hold_val_r != '0);
        okind_nxt = 1'b0;
        okey_nxt  = hold_key_r;
        oval_nxt  = hold_val_r;
        ohit_nxt  = 1'b0;
        oocc_nxt  = occ - 1'b1;
        osum_nxt  = alu_res;
        olast_nxt = 1'b0;
      end
      S_EVCHK: begin
        if (op_r == OP_INVAL_ALL && occ == '0) sum_nxt = '0;
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        okind_nxt = 1'b1;
        okey_nxt  = key_r;
        oval_nxt  = (op_r == OP_GET) ? (hit_r ? hold_val_r : val_r) : '0;
        ohit_nxt  = (op_r == OP_INVAL_ALL) ? 1'b0 : hit_r;
        oocc_nxt  = occ;
        osum_nxt  = sum_r;
        olast_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      pend_r     <= 1'b0;
      hit_r      <= 1'b0;
      free_vld_r <= 1'b0;
      ins_pend_r <= 1'b0;
      sum_r      <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
      hit_r      <= hit_nxt;
      free_vld_r <= free_vld_nxt;
      ins_pend_r <= ins_pend_nxt;
      sum_r      <= sum_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r  <= op_t'(in_op);
      key_r <= in_key;
      val_r <= in_value;
      // a null handle carries no weight
      w_r   <= (in_value == '0) ? '0 : in_weight;
    end
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    free_r     <= free_nxt;
    hold_key_r <= hold_key_nxt;
    hold_val_r <= hold_val_nxt;
    hold_w_r   <= hold_w_nxt;
    okind_r    <= okind_nxt;
    okey_r     <= okey_nxt;
    oval_r     <= oval_nxt;
    ohit_r     <= ohit_nxt;
    oocc_r     <= oocc_nxt;
    osum_r     <= osum_nxt;
    olast_r    <= olast_nxt;
  end

  assign occ_ext          = {{OCC_OUT_W{1'b0}}, oocc_r};
  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_key_out      = okey_r;
  assign out_value_out    = oval_r;
  assign out_hit          = ohit_r;
  assign out_occupancy    = occ_ext[OCC_OUT_W-1:0];
  assign out_total_weight = osum_r;
  assign out_last         = olast_r;

endmodule

FILE: hw/rtl/wlc_ram.sv
module wlc_ram
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 16)
  (input  logic                     clk,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/wlc_age.sv
// Recency ranks and valid bits; rank 0 is most recent.
module wlc_age
  import wlc_pkg::*;
  #(parameter int ENTRIES = ENTRIES_DEF)
  (input  logic                           clk,
   input  logic                           rst_n,
   input  age_op_t                        op,
   input  logic [$clog2(ENTRIES)-1:0]     slot,
   input  logic [$clog2(ENTRIES)-1:0]     q_idx,
   output logic [$clog2(ENTRIES)-1:0]     q_age,
   output logic [ENTRIES-1:0]             valid,
   output logic [$clog2(ENTRIES+1)-1:0]   occ);

  localparam int SW = $clog2(ENTRIES);
  localparam int OW = $clog2(ENTRIES+1);

  logic [SW-1:0]      age_r   [ENTRIES];
  logic [SW-1:0]      age_nxt [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [SW-1:0]      a;

  assign a     = age_r[slot];
  assign q_age = age_r[q_idx];
  assign valid = valid_r;
  assign occ   = occ_r;

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
      case (op)
        AGE_PROMOTE: if (valid_r[i] && age_r[i] < a) age_nxt[i] = age_r[i] + 1'b1;
        AGE_REMOVE:  if (valid_r[i] && age_r[i] > a) age_nxt[i] = age_r[i] - 1'b1;
        AGE_INSERT:  if (valid_r[i]) age_nxt[i] = age_r[i] + 1'b1;
        default: ;
      endcase
    end
    case (op)
      AGE_PROMOTE: age_nxt[slot] = '0;
      AGE_REMOVE: begin
        age_nxt[slot]   = '0;
        valid_nxt[slot] = 1'b0;
        occ_nxt         = occ_r - 1'b1;
      end
      AGE_INSERT: begin
        age_nxt[slot]   = '0;
        valid_nxt[slot] = 1'b1;
        occ_nxt         = occ_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= age_nxt[i];
    end
  end

endmodule

FILE: hw/rtl/wlc_chk.sv
module wlc_chk
  import wlc_pkg::*;
  (input logic                 clk,
   input logic                 rst_n,
   input logic                 start,
   input logic                 busy,
   input logic                 out_valid,
   input logic                 out_kind,
   input logic                 out_hit,
   input logic                 out_last);

  // every word ends a command exactly when it is a completion
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind))
    else $error("last flag disagrees with word kind");

  a_notice_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_hit)
    else $error("eviction notice carries hit");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command taken without going busy");

  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("word follows completion");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("notice while idle");

endmodule

bind weighted_lru_cache_top wlc_chk u_wlc_chk (.*);
